/* hdl/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
package u2u_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned RemW    = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [UnitW-1:0] CapacityReset = 16'hFFFF;

  // Register index of the capacity register.
  localparam logic RegCapacity = 1'b0;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [RemW-1:0]  remaining;
    logic [UnitW-1:0] bits;
    logic             cont_ok;
    logic             halted;
    logic [UnitW-1:0] count;
  } stream_state_t;

  localparam stream_state_t StreamReset = '{
    remaining: '0,
    bits:      '0,
    cont_ok:   1'b1,
    halted:    1'b0,
    count:     '0
  };

  // What one byte yields.
  typedef struct packed {
    logic             produce;
    logic [UnitW-1:0] unit;
    logic             wrote;
    logic             done;
    logic [UnitW-1:0] count;
  } step_result_t;

endpackage

/* hdl/u2u_step.sv */
// Combinational next-state and result logic for one UTF-8 byte.
module u2u_step (
  input  u2u_pkg::stream_state_t    state_i,
  input  logic [7:0]                byte_i,
  input  logic                      last_i,
  input  logic [u2u_pkg::UnitW-1:0] capacity_i,
  output u2u_pkg::stream_state_t    state_o,
  output u2u_pkg::step_result_t     result_o
);
  import u2u_pkg::*;

  stream_state_t nxt;
  logic          complete;
  logic          wrote;
  logic [UnitW-1:0] unit;

  always_comb begin
    nxt      = state_i;
    complete = 1'b0;
    wrote    = 1'b0;
    unit     = '0;

    if (!state_i.halted) begin
      if (state_i.remaining == '0) begin
        if (!byte_i[7]) begin
          nxt.bits = {8'h00, byte_i};
          complete = 1'b1;
        end else if (!byte_i[6]) begin
          // A continuation byte where a lead byte belongs stops decoding.
          nxt.halted = 1'b1;
        end else begin
          if (!byte_i[5]) begin
            nxt.remaining = 3'd1;
            nxt.bits      = {11'd0, byte_i[4:0]};
          end else if (!byte_i[4]) begin
            nxt.remaining = 3'd2;
            nxt.bits      = {12'd0, byte_i[3:0]};
          end else if (!byte_i[3]) begin
            nxt.remaining = 3'd3;
            nxt.bits      = {13'd0, byte_i[2:0]};
          end else if (!byte_i[2]) begin
            nxt.remaining = 3'd4;
            nxt.bits      = {14'd0, byte_i[1:0]};
          end else begin
            nxt.remaining = 3'd5;
            nxt.bits      = {15'd0, byte_i[0]};
          end
          nxt.cont_ok = 1'b1;
        end
      end else begin
        if (byte_i[7:6] != 2'b10) begin
          nxt.cont_ok = 1'b0;
        end
        nxt.bits      = {state_i.bits[UnitW-7:0], byte_i[5:0]};
        nxt.remaining = state_i.remaining - 3'd1;
        complete      = (state_i.remaining == 3'd1);
      end

      if (complete) begin
        if (state_i.count >= capacity_i) begin
          nxt.halted = 1'b1;
        end else begin
          unit      = nxt.cont_ok ? nxt.bits : '0;
          nxt.count = state_i.count + 16'd1;
          wrote     = 1'b1;
        end
        nxt.bits    = '0;
        nxt.cont_ok = 1'b1;
      end
    end
  end

  assign result_o.produce = wrote | last_i;
  assign result_o.unit    = unit;
  assign result_o.wrote   = wrote;
  assign result_o.done    = last_i;
  assign result_o.count   = nxt.count;

  // The end of a string returns the decoder to its starting state.
  assign state_o = last_i ? StreamReset : nxt;

endmodule

/* hdl/utf8_to_ucs2_stream_decoder.sv */
// Top level of the UTF-8 to 16-bit code unit stream decoder.
//
// The decoder takes one UTF-8 byte per item and turns each complete sequence
// (one to six bytes, length set by the lead byte) into one item holding the
// low 16 bits of the code point, or zero when a continuation byte of the
// sequence was not of the form 10xxxxxx. A byte flagged end_of_input always
// yields an item with done_res set and the count of units written in the
// string; an unfinished sequence at that point is dropped, and the decoder
// then starts over for the next string. A stray continuation byte in lead
// position, or a unit that would exceed the capacity register, stops
// decoding until the end flag. Bytes that neither complete a unit nor end the
// string produce no item. The block takes one byte every clock while the
// output is not stalled: a byte is captured in an input register, decoded
// by a single pass of logic against the stream state, and its item is
// registered in the output register when the byte moves on. A stalled
// output holds the pipeline: the input register can still take one byte
// while it is empty, and once it holds a byte the input stalls until the
// output register is read. The capacity register (reset 65535) sits at
// byte address 0 of the APB port and should be written only while the
// decoder is idle.
module utf8_to_ucs2_stream_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      end_of_input_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [u2u_pkg::UnitW-1:0] code_unit_o,
  output logic                      unit_valid_o,
  output logic                      done_res_o,
  output logic [u2u_pkg::UnitW-1:0] units_written_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [u2u_pkg::AddrW-1:0] paddr,
  input  logic [u2u_pkg::DataW-1:0] pwdata,
  output logic [u2u_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import u2u_pkg::*;

  // Configuration register.
  logic [UnitW-1:0] capacity_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[AddrW-1] == RegCapacity);
  assign prdata    = (paddr[AddrW-1] == RegCapacity) ? {16'd0, capacity_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_write) begin
      capacity_q <= pwdata[UnitW-1:0];
    end
  end

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       advance;
  logic       in_accept;

  // The captured byte moves on whenever the output register can take a result.
  assign advance    = in_vld_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_accept  = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      in_end_q  <= end_of_input_i;
    end
  end

  // Stream state and the decode step.
  stream_state_t state_q;
  stream_state_t state_d;
  step_result_t  result;

  u2u_step u_step (
    .state_i    (state_q),
    .byte_i     (in_byte_q),
    .last_i     (in_end_q),
    .capacity_i (capacity_q),
    .state_o    (state_d),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StreamReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  logic             out_vld_q;
  logic [UnitW-1:0] unit_q;
  logic             wrote_q;
  logic             done_q;
  logic [UnitW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= result.produce;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.produce) begin
      unit_q  <= result.unit;
      wrote_q <= result.wrote;
      done_q  <= result.done;
      count_q <= result.count;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign code_unit_o     = unit_q;
  assign unit_valid_o    = wrote_q;
  assign done_res_o      = done_q;
  assign units_written_o = count_q;

endmodule
